// ----- design/kvp_pkg.sv -----
// Shared types, codes and keyword tables of the key-value text reply parser.
package kvp_pkg;

    localparam int DEF_LENGTH_BITS = 32;
    localparam int CL_WIDTH        = 32;
    localparam int STATUS_WIDTH    = 10;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [STATUS_WIDTH-1:0] MISS_STATUS_RESET = 10'd404;
    localparam logic [STATUS_WIDTH-1:0] STATUS_OK         = 10'd200;
    localparam logic [STATUS_WIDTH-1:0] STATUS_NO_CONTENT = 10'd204;

    localparam logic [1:0] OP_GET = 2'd0;
    localparam logic [1:0] OP_PUT = 2'd1;

    localparam logic [2:0] KIND_HEADER_OK  = 3'd0;
    localparam logic [2:0] KIND_VALUE_BYTE = 3'd1;
    localparam logic [2:0] KIND_BAD_HEADER = 3'd2;
    localparam logic [2:0] KIND_BAD_TRAIL  = 3'd3;
    localparam logic [2:0] KIND_DONE       = 3'd4;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int KW_COUNT    = 5;
    localparam int KW_END      = 0;
    localparam int KW_STORED   = 1;
    localparam int KW_DELETED  = 2;
    localparam int KW_NOTFOUND = 3;
    localparam int KW_VALUE    = 4;

    localparam logic [7:0] PREFIX_LEN    = 8'd6;
    localparam logic [7:0] VALUE_MIN_LEN = 8'd10;
    localparam logic [2:0] TRAILER_LAST  = 3'd6;

    localparam logic [3:0] KW_LEN [0:4] = '{4'd3, 4'd6, 4'd7, 4'd9, 4'd6};

    localparam logic [7:0] KW_TEXT [0:4][0:9] = '{
        '{8'h45, 8'h4E, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h53, 8'h54, 8'h4F, 8'h52, 8'h45, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45, 8'h44, 8'h00, 8'h00, 8'h00},
        '{8'h4E, 8'h4F, 8'h54, 8'h5F, 8'h46, 8'h4F, 8'h55, 8'h4E, 8'h44, 8'h00},
        '{8'h56, 8'h41, 8'h4C, 8'h55, 8'h45, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [7:0] TRAILER_TEXT [0:6] =
        '{8'h0D, 8'h0A, 8'h45, 8'h4E, 8'h44, 8'h0D, 8'h0A};

    // One classified input transaction as it travels from the front to the back.
    typedef struct packed {
        logic       is_start;
        logic [1:0] op;
        logic [7:0] data;
        logic       is_lf;
        logic       is_cr;
        logic       is_space;
        logic       is_digit;
        logic [3:0] digit;
    } kvp_item_t;

endpackage

// ----- design/kv_text_response_parser_unit.sv -----
// Top level of the key-value text reply parser: front queue, back parser, checks.
//
// Usage: the input channel (in_valid / in_stall) carries one transaction per cycle
// while in_stall is low. A transaction with req_type 0 starts a new reply and
// latches operation (get, put, delete); a transaction with req_type 1 carries one
// reply byte in data_byte. The output channel (out_valid / out_stall) carries at
// most one result transaction per input transaction: header verdict, passed-through
// value byte, bad trailer or reply complete, in the same order as the inputs that
// cause them. Throughput is one input transaction per cycle while no back-pressure
// holds the output register; each byte takes constant work in the back parser,
// which is the single stage that sets the rate. An accepted input is registered in
// the front queue, and its result then in the output register of the back parser.
// The two-entry queue between front and back lets in_stall stay low while a result
// waits to be taken; when out_stall holds the output register, the back stops
// taking items and in_stall rises once the queue is full.
// Reset clears the queue, sets the parser idle (bytes before a start are dropped)
// and loads the not-found status register with 404. cfg_wr_en writes that status
// register; write it only while the block is idle.
module kv_text_response_parser_unit #(
    parameter int LENGTH_BITS = kvp_pkg::DEF_LENGTH_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [kvp_pkg::STATUS_WIDTH-1:0]  cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              req_type,
    input  logic [1:0]                        operation,
    input  logic [7:0]                        data_byte,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [2:0]                        kind,
    output logic [kvp_pkg::STATUS_WIDTH-1:0]  status_code,
    output logic [kvp_pkg::CL_WIDTH-1:0]      content_length,
    output logic [7:0]                        value_byte
);

    logic               head_valid;
    kvp_pkg::kvp_item_t head;
    logic               pop;

    // The front classifies each transaction and queues it for the parser.
    kvp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .operation  (operation),
        .data_byte  (data_byte),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // The back runs the reply state machine and owns the output register.
    kvp_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .head_valid     (head_valid),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .status_code    (status_code),
        .content_length (content_length),
        .value_byte     (value_byte)
    );

    // The parser only takes an item that the queue actually holds.
    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("parser took an item from an empty queue");

    // The queue can only fill up while the output side holds a result back.
    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stalled without output back-pressure");

    // Only an accepted header verdict carries a status and a length.
    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind != kvp_pkg::KIND_HEADER_OK)) |->
            ((status_code == '0) && (content_length == '0)))
        else $error("status or length set on a non-header result");

endmodule

// ----- design/kvp_front.sv -----
// Front part: accepts input transactions, classifies them and queues them.
module kvp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              req_type,
    input  logic [1:0]        operation,
    input  logic [7:0]        data_byte,
    output logic              head_valid,
    output kvp_pkg::kvp_item_t head,
    input  logic              pop
);

    localparam int PTR_W = (kvp_pkg::QUEUE_DEPTH > 1) ? $clog2(kvp_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(kvp_pkg::QUEUE_DEPTH + 1);

    kvp_pkg::kvp_item_t entry_reg [kvp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    kvp_pkg::kvp_item_t item;
    logic               push;

    always_comb
    begin
        item.is_start = ~req_type;
        item.op       = operation;
        item.data     = data_byte;
        item.is_lf    = (data_byte == kvp_pkg::CH_LF);
        item.is_cr    = (data_byte == kvp_pkg::CH_CR);
        item.is_space = (data_byte == kvp_pkg::CH_SPACE);
        item.is_digit = (data_byte >= kvp_pkg::CH_ZERO) && (data_byte <= kvp_pkg::CH_NINE);
        item.digit    = data_byte[3:0];
    end

    assign in_stall   = (count_reg == CNT_W'(kvp_pkg::QUEUE_DEPTH));
    assign push       = in_valid && !in_stall;
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(kvp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(kvp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

// ----- design/kvp_back.sv -----
// Back part: reply parser state machine with the output register.
module kvp_back #(
    parameter int LENGTH_BITS = kvp_pkg::DEF_LENGTH_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [kvp_pkg::STATUS_WIDTH-1:0]  cfg_wr_data,
    input  logic                              head_valid,
    input  kvp_pkg::kvp_item_t                head,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [2:0]                        kind,
    output logic [kvp_pkg::STATUS_WIDTH-1:0]  status_code,
    output logic [kvp_pkg::CL_WIDTH-1:0]      content_length,
    output logic [7:0]                        value_byte
);

    localparam int WB = LENGTH_BITS + 4;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_HEADER  = 5'b00010,
        PH_VALUE   = 5'b00100,
        PH_TRAILER = 5'b01000,
        PH_DROP    = 5'b10000
    } phase_t;

    phase_t                           phase_reg, phase_next;
    logic [kvp_pkg::STATUS_WIDTH-1:0] nf_status_reg;
    logic [1:0]                       op_reg, op_next;
    logic [7:0]                       line_len_reg, line_len_next;
    logic [4:0]                       flags_reg, flags_next;
    logic                             cr_pend_reg, cr_pend_next;
    logic [1:0]                       spaces_reg, spaces_next;
    logic [LENGTH_BITS-1:0]           acc_reg, acc_next;
    logic [1:0]                       dstat_reg, dstat_next;
    logic [LENGTH_BITS-1:0]           vleft_reg, vleft_next;
    logic [2:0]                       trl_pos_reg, trl_pos_next;

    logic                             out_valid_reg, out_valid_next;
    logic [2:0]                       out_kind_reg;
    logic [kvp_pkg::STATUS_WIDTH-1:0] out_status_reg;
    logic [kvp_pkg::CL_WIDTH-1:0]     out_len_reg;
    logic [7:0]                       out_byte_reg;

    logic                             res_valid;
    logic [2:0]                       res_kind;
    logic [kvp_pkg::STATUS_WIDTH-1:0] res_status;
    logic [kvp_pkg::CL_WIDTH-1:0]     res_len;
    logic [7:0]                       res_byte;

    // State after a pending CR has been taken into the line.
    logic [7:0]                       pos_a;
    logic [4:0]                       flags_a;
    logic [1:0]                       dstat_a;
    logic [WB-1:0]                    acc_x10;
    logic                             acc_ovf;
    logic [kvp_pkg::CL_WIDTH-1:0]     acc_low;
    logic                             out_free;

    function automatic logic [4:0] kw_hit(input logic [7:0] pos, input logic [7:0] c);
        logic [4:0] hit;
        for (int k = 0; k < kvp_pkg::KW_COUNT; k++)
        begin
            hit[k] = (pos >= {4'b0, kvp_pkg::KW_LEN[k]}) || (c == kvp_pkg::KW_TEXT[k][pos[3:0]]);
        end
        return hit;
    endfunction

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic logic exact(input logic [4:0] flags, input logic [7:0] len, input int k);
        return flags[k] && (len == {4'b0, kvp_pkg::KW_LEN[k]});
    endfunction

    if (LENGTH_BITS >= kvp_pkg::CL_WIDTH)
    begin : g_len_wide
        assign acc_low = acc_reg[kvp_pkg::CL_WIDTH-1:0];
    end
    else
    begin : g_len_narrow
        assign acc_low = {{(kvp_pkg::CL_WIDTH - LENGTH_BITS){1'b0}}, acc_reg};
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = head_valid && out_free;

    always_comb
    begin
        if (cr_pend_reg)
        begin
            pos_a   = sat_inc(line_len_reg);
            flags_a = flags_reg & kw_hit(line_len_reg, kvp_pkg::CH_CR);
            dstat_a = dstat_reg;
            if ((line_len_reg >= kvp_pkg::PREFIX_LEN) && (spaces_reg == 2'd2))
            begin
                dstat_a[1] = 1'b1;
            end
        end
        else
        begin
            pos_a   = line_len_reg;
            flags_a = flags_reg;
            dstat_a = dstat_reg;
        end
        acc_x10 = {1'b0, acc_reg, 3'b0} + {3'b0, acc_reg, 1'b0} + WB'(head.digit);
        acc_ovf = |acc_x10[WB-1:LENGTH_BITS];
    end

    always_comb
    begin
        phase_next    = phase_reg;
        op_next       = op_reg;
        line_len_next = line_len_reg;
        flags_next    = flags_reg;
        cr_pend_next  = cr_pend_reg;
        spaces_next   = spaces_reg;
        acc_next      = acc_reg;
        dstat_next    = dstat_reg;
        vleft_next    = vleft_reg;
        trl_pos_next  = trl_pos_reg;
        res_valid     = 1'b0;
        res_kind      = kvp_pkg::KIND_HEADER_OK;
        res_status    = '0;
        res_len       = '0;
        res_byte      = '0;

        if (pop)
        begin
            if (head.is_start)
            begin
                op_next       = head.op;
                phase_next    = PH_HEADER;
                line_len_next = '0;
                flags_next    = '1;
                cr_pend_next  = 1'b0;
                spaces_next   = '0;
                acc_next      = '0;
                dstat_next    = '0;
                vleft_next    = '0;
                trl_pos_next  = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (head.is_lf)
                        begin
                            cr_pend_next = 1'b0;
                            phase_next   = PH_DROP;
                            res_valid    = 1'b1;
                            res_kind     = kvp_pkg::KIND_BAD_HEADER;
                            case (op_reg)
                                kvp_pkg::OP_GET:
                                begin
                                    if (exact(flags_reg, line_len_reg, kvp_pkg::KW_END))
                                    begin
                                        res_kind   = kvp_pkg::KIND_HEADER_OK;
                                        res_status = nf_status_reg;
                                    end
                                    else if (flags_reg[kvp_pkg::KW_VALUE] &&
                                             (line_len_reg >= kvp_pkg::VALUE_MIN_LEN) &&
                                             (spaces_reg == 2'd2) && (dstat_reg == 2'b01))
                                    begin
                                        res_kind     = kvp_pkg::KIND_HEADER_OK;
                                        res_status   = kvp_pkg::STATUS_OK;
                                        res_len      = acc_low;
                                        vleft_next   = acc_reg;
                                        trl_pos_next = '0;
                                        phase_next   = (acc_reg != '0) ? PH_VALUE : PH_TRAILER;
                                    end
                                end
                                kvp_pkg::OP_PUT:
                                begin
                                    if (exact(flags_reg, line_len_reg, kvp_pkg::KW_STORED))
                                    begin
                                        res_kind   = kvp_pkg::KIND_HEADER_OK;
                                        res_status = kvp_pkg::STATUS_NO_CONTENT;
                                    end
                                end
                                default:
                                begin
                                    if (exact(flags_reg, line_len_reg, kvp_pkg::KW_DELETED))
                                    begin
                                        res_kind   = kvp_pkg::KIND_HEADER_OK;
                                        res_status = kvp_pkg::STATUS_NO_CONTENT;
                                    end
                                    else if (exact(flags_reg, line_len_reg,
                                                   kvp_pkg::KW_NOTFOUND))
                                    begin
                                        res_kind   = kvp_pkg::KIND_HEADER_OK;
                                        res_status = nf_status_reg;
                                    end
                                end
                            endcase
                        end
                        else
                        begin
                            cr_pend_next  = head.is_cr;
                            line_len_next = pos_a;
                            flags_next    = flags_a;
                            dstat_next    = dstat_a;
                            if (!head.is_cr)
                            begin
                                // A CR never touches the accumulator, so the digit path
                                // works from the stored accumulator.
                                line_len_next = sat_inc(pos_a);
                                flags_next    = flags_a & kw_hit(pos_a, head.data);
                                if (pos_a >= kvp_pkg::PREFIX_LEN)
                                begin
                                    if (spaces_reg != 2'd2)
                                    begin
                                        if (head.is_space)
                                        begin
                                            spaces_next = spaces_reg + 2'd1;
                                        end
                                    end
                                    else if (!dstat_a[1])
                                    begin
                                        if (head.is_digit && !acc_ovf)
                                        begin
                                            acc_next      = acc_x10[LENGTH_BITS-1:0];
                                            dstat_next[0] = 1'b1;
                                        end
                                        else
                                        begin
                                            dstat_next[1] = 1'b1;
                                        end
                                    end
                                end
                            end
                        end
                    end
                    PH_VALUE:
                    begin
                        vleft_next = vleft_reg - 1'b1;
                        if (vleft_reg == LENGTH_BITS'(1))
                        begin
                            phase_next   = PH_TRAILER;
                            trl_pos_next = '0;
                        end
                        res_valid = 1'b1;
                        res_kind  = kvp_pkg::KIND_VALUE_BYTE;
                        res_byte  = head.data;
                    end
                    PH_TRAILER:
                    begin
                        if (head.data != kvp_pkg::TRAILER_TEXT[trl_pos_reg])
                        begin
                            phase_next = PH_DROP;
                            res_valid  = 1'b1;
                            res_kind   = kvp_pkg::KIND_BAD_TRAIL;
                        end
                        else if (trl_pos_reg == kvp_pkg::TRAILER_LAST)
                        begin
                            phase_next = PH_DROP;
                            res_valid  = 1'b1;
                            res_kind   = kvp_pkg::KIND_DONE;
                        end
                        else
                        begin
                            trl_pos_next = trl_pos_reg + 3'd1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nf_status_reg <= kvp_pkg::MISS_STATUS_RESET;
            phase_reg     <= PH_IDLE;
            op_reg        <= '0;
            line_len_reg  <= '0;
            flags_reg     <= '1;
            cr_pend_reg   <= 1'b0;
            spaces_reg    <= '0;
            acc_reg       <= '0;
            dstat_reg     <= '0;
            vleft_reg     <= '0;
            trl_pos_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                nf_status_reg <= cfg_wr_data;
            end
            phase_reg     <= phase_next;
            op_reg        <= op_next;
            line_len_reg  <= line_len_next;
            flags_reg     <= flags_next;
            cr_pend_reg   <= cr_pend_next;
            spaces_reg    <= spaces_next;
            acc_reg       <= acc_next;
            dstat_reg     <= dstat_next;
            vleft_reg     <= vleft_next;
            trl_pos_reg   <= trl_pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            out_kind_reg   <= res_kind;
            out_status_reg <= res_status;
            out_len_reg    <= res_len;
            out_byte_reg   <= res_byte;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = out_kind_reg;
    assign status_code    = out_status_reg;
    assign content_length = out_len_reg;
    assign value_byte     = out_byte_reg;

endmodule
